/* rtl/ffa_pkg.sv */
package ffa_pkg;

  localparam int unsigned AW = 32;
  localparam logic [AW-1:0] ARENA_RESET = 32'h0400_0000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_POOL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  typedef struct packed {
    logic          v;
    logic [AW-1:0] start;
    logic [AW-1:0] len;
  } seg_t;

  localparam seg_t SEG_EMPTY = '{v: 1'b0, start: '0, len: '0};
  localparam seg_t SEG_RESET = '{v: 1'b1, start: '0, len: ARENA_RESET};

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ROT,
    OP_INS,
    OP_DEL,
    OP_WR,
    OP_INIT
  } op_e;

  typedef struct packed {
    op_e  op;
    seg_t data;
  } cmd_t;

endpackage

/* rtl/ffa_cell.sv */
module ffa_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned IW   = 6,
  parameter bit          LAST = 1'b0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ffa_pkg::cmd_t  cmd_i,
  input  logic [IW-1:0]  k_i,
  input  ffa_pkg::seg_t  left_i,
  input  ffa_pkg::seg_t  right_i,
  output ffa_pkg::seg_t  seg_o
);
  import ffa_pkg::*;

  localparam logic [IW-1:0] MY = IW'(IDX);

  seg_t seg_d, seg_q;

  always_comb begin
    seg_d = seg_q;
    case (cmd_i.op)
      OP_ROT: seg_d = right_i;
      OP_INS: begin
        if (MY > k_i) seg_d = left_i;
        else if (MY == k_i) seg_d = cmd_i.data;
      end
      OP_DEL: begin
        if (MY >= k_i) seg_d = LAST ? SEG_EMPTY : right_i;
      end
      OP_WR: begin
        if (MY == k_i) seg_d = cmd_i.data;
      end
      OP_INIT: seg_d = (IDX == 0) ? cmd_i.data : SEG_EMPTY;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= (IDX == 0) ? SEG_RESET : SEG_EMPTY;
    end else begin
      seg_q <= seg_d;
    end
  end

  assign seg_o = seg_q;

endmodule

/* rtl/first_fit_aligned_allocator.sv */
// First-fit allocator over one arena. Free segments sit in offset order in a
// row of SEG_ENTRIES cells; a request rotates the whole row once past a
// two-stage compare unit, and every request other than an immediate reject
// then passes through S_LAST and S_DECIDE to the done strobe, adding S_EDIT2
// when a segment is split or two neighbours are merged. Zero-size requests,
// oversize allocates and frees outside the arena answer in the next cycle.
// The result is shown on done_o for one cycle only and is
// not held: the receiver must take it then. busy is low again in that cycle.
module first_fit_aligned_allocator #(
  parameter int unsigned SEG_ENTRIES = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   func_i,
  input  logic [31:0]            req_size_i,
  input  logic [4:0]             align_log2_i,
  input  logic [31:0]            block_offset_i,
  input  logic                   cfg_we_i,
  input  logic [31:0]            cfg_wdata_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [31:0]            offset_out_o
);
  import ffa_pkg::*;

  localparam int unsigned N  = SEG_ENTRIES;
  localparam int unsigned IW = $clog2(N);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_DECIDE, S_EDIT2} state_e;

  state_e state_q;

  seg_t cells [N];
  cmd_t cmd;
  logic [IW-1:0] cmd_k;

  logic          func_q;
  logic [31:0]   size_q, off_q, arena_q;
  logic [4:0]    lg_q;
  logic [IW-1:0] cnt_q;

  // compare pipe, stage A
  seg_t          a_e_q;
  logic [IW-1:0] a_idx_q;
  logic [32:0]   a_al_q, a_end_q;
  logic          a_lt_q, a_live_q;

  // captures
  logic          found_q, stop_q;
  logic [IW-1:0] k_q, p_idx_q;
  logic [31:0]   f_s_q;
  logic [32:0]   f_al_q, f_end_q;
  logic          p_v_q, nx_v_q;
  logic [31:0]   p_s_q, p_l_q, nx_s_q, nx_l_q;

  cmd_t          op2_q;
  logic [IW-1:0] k2_q;

  logic          done_q;
  logic [1:0]    status_q;
  logic [31:0]   offset_q;

  genvar g;
  for (g = 0; g < N; g++) begin : g_cell
    ffa_cell #(.IDX(g), .IW(IW), .LAST(g == N - 1)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .k_i    (cmd_k),
      .left_i (cells[(g + N - 1) % N]),
      .right_i(cells[(g + 1) % N]),
      .seg_o  (cells[g])
    );
  end

  logic full;
  assign full = cells[N-1].v;

  // stage A feed
  logic [32:0] am, c0_al, c0_end;
  always_comb begin
    am     = (33'd1 << lg_q) - 33'd1;
    c0_al  = ({1'b0, cells[0].start} + am) & ~am;
    c0_end = {1'b0, cells[0].start} + {1'b0, cells[0].len};
  end

  logic fit;
  assign fit = a_e_q.v && (({1'b0, a_al_q} + {2'b0, size_q}) <= {1'b0, a_end_q});

  // decision
  cmd_t          dec_cmd, dec_op2;
  logic [IW-1:0] dec_k;
  logic          dec_two;
  logic [1:0]    dec_st;
  logic [31:0]   dec_off;
  logic [32:0]   alsz, pend, oend;
  logic [31:0]   gap, rest;
  logic          gap_nz, rest_nz, pa, na;

  always_comb begin
    alsz    = f_al_q + {1'b0, size_q};
    gap     = f_al_q[31:0] - f_s_q;
    rest    = 32'(f_end_q - alsz);
    gap_nz  = f_al_q != {1'b0, f_s_q};
    rest_nz = alsz != f_end_q;
    pend    = {1'b0, p_s_q} + {1'b0, p_l_q};
    oend    = {1'b0, off_q} + {1'b0, size_q};
    pa      = p_v_q && (pend == {1'b0, off_q});
    na      = nx_v_q && (oend == {1'b0, nx_s_q});
    dec_cmd = '{op: OP_HOLD, data: SEG_EMPTY};
    dec_op2 = '{op: OP_HOLD, data: SEG_EMPTY};
    dec_k   = k_q;
    dec_two = 1'b0;
    dec_st  = ST_OK;
    dec_off = '0;
    if (func_q == FN_ALLOC) begin
      if (!found_q) begin
        dec_st = ST_NOFIT;
      end else if (gap_nz && rest_nz && full) begin
        dec_st = ST_POOL;
      end else begin
        dec_off = f_al_q[31:0];
        if (gap_nz) begin
          dec_cmd = '{op: OP_WR, data: '{v: 1'b1, start: f_s_q, len: gap}};
          if (rest_nz) begin
            dec_two = 1'b1;
            dec_op2 = '{op: OP_INS, data: '{v: 1'b1, start: alsz[31:0], len: rest}};
          end
        end else if (rest_nz) begin
          dec_cmd = '{op: OP_WR, data: '{v: 1'b1, start: alsz[31:0], len: rest}};
        end else begin
          dec_cmd = '{op: OP_DEL, data: SEG_EMPTY};
        end
      end
    end else begin
      if (pa) begin
        dec_k = p_idx_q;
        if (na) begin
          dec_cmd = '{op: OP_WR,
                      data: '{v: 1'b1, start: p_s_q, len: p_l_q + size_q + nx_l_q}};
          dec_two = 1'b1;
          dec_op2 = '{op: OP_DEL, data: SEG_EMPTY};
        end else begin
          dec_cmd = '{op: OP_WR, data: '{v: 1'b1, start: p_s_q, len: p_l_q + size_q}};
        end
      end else if (na) begin
        dec_cmd = '{op: OP_WR, data: '{v: 1'b1, start: off_q, len: nx_l_q + size_q}};
      end else if (full) begin
        dec_st = ST_POOL;
      end else begin
        dec_cmd = '{op: OP_INS, data: '{v: 1'b1, start: off_q, len: size_q}};
      end
    end
  end

  always_comb begin
    cmd   = '{op: OP_HOLD, data: SEG_EMPTY};
    cmd_k = k_q;
    if (cfg_we_i) begin
      cmd = '{op: OP_INIT, data: '{v: |cfg_wdata_i, start: '0, len: cfg_wdata_i}};
    end else begin
      unique case (state_q)
        S_SCAN:   cmd = '{op: OP_ROT, data: SEG_EMPTY};
        S_DECIDE: begin
          cmd   = dec_cmd;
          cmd_k = dec_k;
        end
        S_EDIT2:  begin
          cmd   = op2_q;
          cmd_k = k2_q;
        end
        default: ;
      endcase
    end
  end

  logic [32:0] in_end;
  logic        accept;
  assign in_end = {1'b0, block_offset_i} + {1'b0, req_size_i};
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      arena_q  <= ARENA_RESET;
      cnt_q    <= '0;
      a_live_q <= 1'b0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      offset_q <= '0;
      found_q  <= 1'b0;
      stop_q   <= 1'b0;
      p_v_q    <= 1'b0;
      nx_v_q   <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      a_live_q <= (state_q == S_SCAN);
      if (cfg_we_i) arena_q <= cfg_wdata_i;

      if (state_q == S_SCAN) begin
        a_e_q   <= cells[0];
        a_idx_q <= cnt_q;
        a_al_q  <= c0_al;
        a_end_q <= c0_end;
        a_lt_q  <= cells[0].start < off_q;
      end

      if (a_live_q) begin
        if (func_q == FN_ALLOC) begin
          if (!found_q && fit) begin
            found_q <= 1'b1;
            k_q     <= a_idx_q;
            f_s_q   <= a_e_q.start;
            f_al_q  <= a_al_q;
            f_end_q <= a_end_q;
          end
        end else if (!stop_q) begin
          if (a_e_q.v && a_lt_q) begin
            p_v_q   <= 1'b1;
            p_idx_q <= a_idx_q;
            p_s_q   <= a_e_q.start;
            p_l_q   <= a_e_q.len;
          end else begin
            stop_q <= 1'b1;
            nx_v_q <= a_e_q.v;
            nx_s_q <= a_e_q.start;
            nx_l_q <= a_e_q.len;
            k_q    <= a_idx_q;
          end
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            func_q  <= func_i;
            size_q  <= req_size_i;
            lg_q    <= align_log2_i;
            off_q   <= block_offset_i;
            cnt_q   <= '0;
            found_q <= 1'b0;
            stop_q  <= 1'b0;
            p_v_q   <= 1'b0;
            nx_v_q  <= 1'b0;
            if (req_size_i == '0) begin
              done_q   <= 1'b1;
              status_q <= ST_OK;
              offset_q <= '0;
            end else if ((func_i == FN_ALLOC && req_size_i >= arena_q) ||
                         (func_i == FN_FREE && in_end > {1'b0, arena_q})) begin
              done_q   <= 1'b1;
              status_q <= ST_RANGE;
              offset_q <= '0;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == IW'(N - 1)) state_q <= S_LAST;
        end
        S_LAST: state_q <= S_DECIDE;
        S_DECIDE: begin
          status_q <= dec_st;
          offset_q <= dec_off;
          op2_q    <= dec_op2;
          k2_q     <= (func_q == FN_ALLOC) ? k_q + 1'b1 : k_q;
          if (dec_two) begin
            state_q <= S_EDIT2;
          end else begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_EDIT2: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy         = state_q != S_IDLE;
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign offset_out_o = offset_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> offset_out_o == '0)
    else $error("failed request carries an offset");

  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |=> state_q == S_SCAN || state_q == S_LAST)
    else $error("rotation left early");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted word produced nothing");

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cells[N-1].v |-> cells[0].v)
    else $error("segment row has a hole");

endmodule
